// ===== rtl/core/status_frame_parser_defines.svh =====
// ----------------------------------------------------------------------------
// status_frame_parser_defines
// Assertion macros shared by the status frame parser RTL.
// ----------------------------------------------------------------------------
`ifndef STATUS_FRAME_PARSER_DEFINES_SVH
`define STATUS_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("status_frame_parser: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("status_frame_parser: next-cycle check failed");

`endif

// ===== rtl/core/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, constants and helpers shared by the status frame parser modules.
// ----------------------------------------------------------------------------
package sfp_pkg;

	// Only the first TEXT_LIMIT bytes of a buffer are scanned as text.
	localparam int TEXT_LIMIT = 255;
	localparam int CNT_W      = $clog2(TEXT_LIMIT + 1);

	localparam logic [7:0] SYNC_HEAD = 8'hAA;
	localparam logic [7:0] SYNC_TAIL = 8'h55;
	localparam logic [6:0] FAN_MAX   = 7'd100;
	localparam int         FRAME_POS = 5;   // bytes before a closing sync byte
	localparam int         TEXT_MIN  = 10;  // a text record needs more bytes than this

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_T     = 8'h54;

	// Output beat layout (tdata), lowest bit first.
	localparam int OUT_W = 40;

	// Position in the text pattern "F:<n>,S:<n>,T:<n>".
	typedef enum logic [3:0] {
		PH_F      = 4'd0,
		PH_COLON1 = 4'd1,
		PH_WS1    = 4'd2,
		PH_NUM1   = 4'd3,
		PH_COMMA1 = 4'd4,
		PH_S      = 4'd5,
		PH_COLON2 = 4'd6,
		PH_WS2    = 4'd7,
		PH_NUM2   = 4'd8,
		PH_COMMA2 = 4'd9,
		PH_T      = 4'd10,
		PH_COLON3 = 4'd11,
		PH_WS3    = 4'd12,
		PH_NUM3   = 4'd13,
		PH_DONE   = 4'd14,
		PH_FAIL   = 4'd15
	} phase_t;

	// One buffer byte as it leaves the input register.
	typedef struct packed {
		logic       en;
		logic       last;
		logic [7:0] data;
	} step_t;

	// Where the current byte sits in its buffer.
	typedef struct packed {
		logic feed;    // byte still inside the text window
		logic past5;   // five bytes precede it
		logic past10;  // buffer length is above the text minimum
	} pos_t;

	typedef struct packed {
		logic        seen;
		logic [7:0]  flags;
		logic [7:0]  fan;
		logic [15:0] temp;
	} frame_info_t;

	typedef struct packed {
		logic        done;
		logic        flame;
		logic [6:0]  fan;
		logic [15:0] temp;
	} text_info_t;

	function automatic phase_t next_phase(input phase_t p);
		return phase_t'(p + 4'd1);
	endfunction

	function automatic logic [7:0] lit_char(input phase_t p);
		logic [7:0] ch;
		case (p)
			PH_F:      ch = CH_F;
			PH_S:      ch = CH_S;
			PH_T:      ch = CH_T;
			PH_COLON1,
			PH_COLON2,
			PH_COLON3: ch = CH_COLON;
			PH_COMMA1,
			PH_COMMA2: ch = CH_COMMA;
			default:   ch = CH_NUL;
		endcase
		return ch;
	endfunction

	function automatic logic [6:0] clamp_fan8(input logic [7:0] v);
		return (v > {1'b0, FAN_MAX}) ? FAN_MAX : v[6:0];
	endfunction

endpackage

// ===== rtl/core/sfp_frame_det.sv =====
// ----------------------------------------------------------------------------
// sfp_frame_det
// Sliding five-byte window that spots the first binary status frame.
// ----------------------------------------------------------------------------
module sfp_frame_det
	import sfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  step_t       step,
	input  pos_t        pos,
	output frame_info_t frame
);

	logic [7:0]  win_q [FRAME_POS];
	logic        seen_q;
	logic [7:0]  flags_q;
	logic [7:0]  fan_q;
	logic [15:0] temp_q;
	logic        hit;

	// The window is only looked at once five bytes of this buffer are in it.
	assign hit = !seen_q && pos.past5 && (win_q[0] == SYNC_HEAD) && (step.data == SYNC_TAIL);

	always_comb begin
		frame.seen  = seen_q || hit;
		frame.flags = hit ? win_q[1] : flags_q;
		frame.fan   = hit ? win_q[2] : fan_q;
		frame.temp  = hit ? {win_q[3], win_q[4]} : temp_q;
	end

	always_ff @(posedge clk) begin
		if (step.en) begin
			for (int i = 0; i < FRAME_POS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[FRAME_POS - 1] <= step.data;
			if (hit) begin
				flags_q <= win_q[1];
				fan_q   <= win_q[2];
				temp_q  <= {win_q[3], win_q[4]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (step.en) begin
			seen_q <= step.last ? 1'b0 : frame.seen;
		end
	end

endmodule

// ===== rtl/core/sfp_text_scan.sv =====
// ----------------------------------------------------------------------------
// sfp_text_scan
// Byte-serial scanner for the text record "F:<n>,S:<n>,T:<n>".
// ----------------------------------------------------------------------------
module sfp_text_scan
	import sfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  step_t      step,
	input  pos_t       pos,
	output text_info_t text
);

	phase_t      ph_q;
	logic        neg_q;
	logic        dig_q;
	logic [31:0] acc_q;
	logic        flame_q;
	logic [6:0]  fan_q;
	logic [15:0] temp_q;

	phase_t      p;
	phase_t      cm_ph;
	logic        n;
	logic        d;
	logic [31:0] a;
	logic        cm;
	logic        cn;
	logic [31:0] ca;
	logic [31:0] cv;
	logic        fin;
	logic        end_req;
	logic        is_digit;
	logic        is_ws;
	logic [3:0]  dv;

	assign is_digit = (step.data >= CH_ZERO) && (step.data <= CH_NINE);
	assign is_ws    = (step.data == CH_SPACE) || (step.data inside {[CH_TAB:CH_CR]});
	assign dv       = step.data[3:0];

	always_comb begin
		p       = ph_q;
		n       = neg_q;
		d       = dig_q;
		a       = acc_q;
		cm      = 1'b0;
		cm_ph   = ph_q;
		cn      = neg_q;
		ca      = acc_q;
		fin     = 1'b0;
		end_req = 1'b0;

		if (!pos.feed) begin
			end_req = 1'b1;
		end else if ((p == PH_DONE) || (p == PH_FAIL)) begin
			fin = 1'b1;
		end else if (step.data == CH_NUL) begin
			end_req = 1'b1;
		end else begin
			if ((p == PH_NUM1) || (p == PH_NUM2) || (p == PH_NUM3)) begin
				if (is_digit) begin
					a   = {a[28:0], 3'b000} + {a[30:0], 1'b0} + {28'd0, dv};
					d   = 1'b1;
					fin = 1'b1;
				end else if (!d) begin
					p   = PH_FAIL;
					fin = 1'b1;
				end else begin
					// A non-digit closes the number and is then matched as usual.
					cm    = 1'b1;
					cm_ph = p;
					cn    = n;
					ca    = a;
					n     = 1'b0;
					d     = 1'b0;
					a     = 32'd0;
					p     = next_phase(p);
					fin   = (p == PH_DONE);
				end
			end
			if (!fin) begin
				if ((p == PH_WS1) || (p == PH_WS2) || (p == PH_WS3)) begin
					if (!is_ws) begin
						n = 1'b0;
						d = 1'b0;
						a = 32'd0;
						if ((step.data == CH_PLUS) || (step.data == CH_MINUS)) begin
							n = (step.data == CH_MINUS);
							p = next_phase(p);
						end else if (is_digit) begin
							a = {28'd0, dv};
							d = 1'b1;
							p = next_phase(p);
						end else begin
							p = PH_FAIL;
						end
					end
				end else if (step.data == lit_char(p)) begin
					p = next_phase(p);
				end else begin
					p = PH_FAIL;
				end
			end
		end

		// End of text: a pending third number with digits still counts.
		if (end_req || step.last) begin
			if ((p == PH_NUM3) && d) begin
				cm    = 1'b1;
				cm_ph = p;
				cn    = n;
				ca    = a;
				p     = PH_DONE;
			end else if (p != PH_DONE) begin
				p = PH_FAIL;
			end
		end

		cv = cn ? (32'd0 - ca) : ca;

		text.done  = (p == PH_DONE);
		text.flame = (cm && (cm_ph == PH_NUM1)) ? (ca != 32'd0) : flame_q;
		if (cm && (cm_ph == PH_NUM2)) begin
			if (cv[31]) begin
				text.fan = 7'd0;
			end else if (cv > {25'd0, FAN_MAX}) begin
				text.fan = FAN_MAX;
			end else begin
				text.fan = cv[6:0];
			end
		end else begin
			text.fan = fan_q;
		end
		text.temp = (cm && (cm_ph == PH_NUM3)) ? cv[15:0] : temp_q;
	end

	always_ff @(posedge clk) begin
		if (step.en) begin
			neg_q   <= n;
			dig_q   <= d;
			acc_q   <= a;
			flame_q <= text.flame;
			fan_q   <= text.fan;
			temp_q  <= text.temp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_F;
		end else if (step.en) begin
			ph_q <= step.last ? PH_F : p;
		end
	end

endmodule

// ===== rtl/core/sfp_record.sv =====
// ----------------------------------------------------------------------------
// sfp_record
// Picks the record of a finished buffer, keeps it and drives the result beat.
// ----------------------------------------------------------------------------
module sfp_record
	import sfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  step_t             step,
	input  pos_t              pos,
	input  frame_info_t       frame,
	input  text_info_t        text,
	input  logic              adv,
	output logic              out_vld,
	output logic [OUT_W-1:0]  out_data,
	output logic              out_user
);

	logic        rec_vld_q;
	logic        rec_flame_q;
	logic [6:0]  rec_fan_q;
	logic [15:0] rec_temp_q;
	logic [6:0]  rec_fault_q;

	logic        found;
	logic        from_text;
	logic        rec_vld_d;
	logic        rec_flame_d;
	logic [6:0]  rec_fan_d;
	logic [15:0] rec_temp_d;
	logic [6:0]  rec_fault_d;

	logic              vld_q;
	logic [OUT_W-1:0]  data_q;
	logic              user_q;

	always_comb begin
		found       = 1'b0;
		from_text   = 1'b0;
		rec_vld_d   = rec_vld_q;
		rec_flame_d = rec_flame_q;
		rec_fan_d   = rec_fan_q;
		rec_temp_d  = rec_temp_q;
		rec_fault_d = rec_fault_q;
		// A binary frame beats any text in the same buffer.
		if (frame.seen) begin
			found       = 1'b1;
			rec_vld_d   = 1'b1;
			rec_flame_d = frame.flags[0];
			rec_fan_d   = clamp_fan8(frame.fan);
			rec_temp_d  = frame.temp;
			rec_fault_d = frame.flags[7:1];
		end else if (pos.past10 && text.done) begin
			found       = 1'b1;
			from_text   = 1'b1;
			rec_vld_d   = 1'b1;
			rec_flame_d = text.flame;
			rec_fan_d   = text.fan;
			rec_temp_d  = text.temp;
			rec_fault_d = 7'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_q   <= 1'b0;
			rec_flame_q <= 1'b0;
			rec_fan_q   <= 7'd0;
			rec_temp_q  <= 16'd0;
			rec_fault_q <= 7'd0;
		end else if (step.en && step.last) begin
			rec_vld_q   <= rec_vld_d;
			rec_flame_q <= rec_flame_d;
			rec_fan_q   <= rec_fan_d;
			rec_temp_q  <= rec_temp_d;
			rec_fault_q <= rec_fault_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= step.en && step.last;
		end
	end

	always_ff @(posedge clk) begin
		if (step.en && step.last) begin
			data_q <= {7'd0, rec_fault_d, rec_temp_d, rec_fan_d, rec_flame_d,
				rec_vld_d, found};
			user_q <= from_text;
		end
	end

	assign out_vld  = vld_q;
	assign out_data = data_q;
	assign out_user = user_q;

endmodule

// ===== rtl/core/status_frame_parser.sv =====
// ----------------------------------------------------------------------------
// status_frame_parser
// Byte-serial parser of binary and text status records from a buffer.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Signals                        Beat
// -------  ---  -----------------------------  -------------------------------
// s        in   s_tvalid s_tready s_tdata s_tlast  one buffer byte, tlast on final
// m        out  m_tvalid m_tready m_tdata m_tuser  one result per finished buffer
//
// One byte is taken every cycle while the result side is not stalled.
// The result of a buffer passes, after its tlast beat is taken, through
// the input register and then through the record logic into the output
// register. Reset is asynchronous and active low and clears the buffer scan
// state and the stored record. A result that is not taken holds the output
// register and the input register and drops s_tready.
//
// A buffer is scanned in two ways at once. A five-byte window looks for the
// first binary frame 0xAA, flags, fan, temp high, temp low, 0x55. In
// parallel a phase machine scans the start of the buffer as the text
// "F:<n>,S:<n>,T:<n>" with scanf-style integers (leading white space, one
// optional sign, decimal digits wrapping modulo 2^32). On the final byte
// the binary frame wins; otherwise a good text record counts when the
// buffer is longer than ten bytes. A good record replaces the stored one,
// and every result beat reports the stored record.
// ----------------------------------------------------------------------------
`include "status_frame_parser_defines.svh"

module status_frame_parser
	import sfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [0] found, [1] record_valid, [2] flame_on,
	                                     // [9:3] fan_percent, [25:10] temperature,
	                                     // [32:26] fault_code, [39:33] zero
	output logic              m_tuser    // [0] from_text
);

	logic             vld_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic [CNT_W-1:0] byte_cnt_q;
	logic             adv;

	step_t       step;
	pos_t        pos;
	frame_info_t frame;
	text_info_t  text;

	// The whole pipe moves unless a finished result is waiting.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign step.en   = vld_s1 && adv;
	assign step.last = last_s1;
	assign step.data = data_s1;

	// Byte position in the buffer; it saturates at the end of the text window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (step.en) begin
			if (step.last) begin
				byte_cnt_q <= '0;
			end else if (byte_cnt_q < CNT_W'(TEXT_LIMIT)) begin
				byte_cnt_q <= byte_cnt_q + 1'b1;
			end
		end
	end

	assign pos.feed   = byte_cnt_q < CNT_W'(TEXT_LIMIT);
	assign pos.past5  = byte_cnt_q >= CNT_W'(FRAME_POS);
	// Length after this byte is above the minimum exactly when at least ten precede it.
	assign pos.past10 = byte_cnt_q >= CNT_W'(TEXT_MIN);

	sfp_frame_det u_frame_det (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pos    (pos),
		.frame  (frame)
	);

	sfp_text_scan u_text_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pos    (pos),
		.text   (text)
	);

	sfp_record u_record (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.pos      (pos),
		.frame    (frame),
		.text     (text),
		.adv      (adv),
		.out_vld  (m_tvalid),
		.out_data (m_tdata),
		.out_user (m_tuser)
	);

	// A found record always leaves the stored record marked as filled.
	`SFP_ASSERT_NOW(a_found_valid, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[1])
	// A text result is always a found result.
	`SFP_ASSERT_NOW(a_text_found, clk, arst_n, m_tvalid && m_tuser, m_tdata[0])
	// The stored fan speed never leaves its clamp.
	`SFP_ASSERT_NOW(a_fan_range, clk, arst_n, m_tvalid, m_tdata[9:3] <= FAN_MAX)
	// An empty output register never holds back the input side.
	`SFP_ASSERT_NOW(a_ready_free, clk, arst_n, !m_tvalid, s_tready)

endmodule
